/* rtl/core/dct3d_8x8x8_fwd_inv_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3-D DCT core
// Shared same-cycle implication and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef DCT3D_8X8X8_FWD_INV_CORE_ASSERT_SVH
`define DCT3D_8X8X8_FWD_INV_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DCT3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DCT3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dct3_pkg.sv */
// ----------------------------------------------------------------------------
// dct3_pkg
// Types, constants and basis helpers for the 8x8x8 DCT core.
// ----------------------------------------------------------------------------
`default_nettype none

package dct3_pkg;

    localparam int ELEM_W  = 16;
    localparam int MID_W   = 24;
    localparam int COEF_W  = 20;
    localparam int ACC_W   = 48;
    localparam int ADDR_W  = 9;

    localparam logic signed [MID_W-1:0] SAT24_MAX = 24'sh7FFFFF;
    localparam logic signed [MID_W-1:0] SAT24_MIN = -24'sh800000;

    // Pass stride codes
    localparam logic [1:0] STRIDE_1  = 2'd0;
    localparam logic [1:0] STRIDE_8  = 2'd1;
    localparam logic [1:0] STRIDE_64 = 2'd2;

    // Configuration register indexes
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_DC_OFFSET = 1'b1;

    localparam longint Q30_MAG [0:8] = '{
        64'd0, 64'd526555088, 64'd496004047, 64'd446391849, 64'd379625062,
        64'd298269498, 64'd205451603, 64'd104738319, 64'd0
    };

    typedef struct packed {
        logic       valid;
        logic [2:0] b;
        logic       inv;
        logic       first_pass;
        logic [2:0] sel;
    } t_mac_ctl;

    // Basis entry (k, n) in Q(cfb)
    function automatic logic signed [COEF_W-1:0] f_basis(input logic [2:0] k,
                                                         input logic [2:0] n,
                                                         input int cfb);
        int     m;
        logic   neg;
        longint mag;
        m   = 4;
        neg = 1'b0;
        if (k != 3'd0) begin
            m = ((2 * int'(n) + 1) * int'(k)) & 31;
            if (m > 16) m = 32 - m;
            if (m > 8) begin
                m   = 16 - m;
                neg = 1'b1;
            end
        end
        mag = (Q30_MAG[4'(m)] + (64'sd1 <<< (29 - cfb))) >>> (30 - cfb);
        if (neg) mag = -mag;
        return COEF_W'(mag);
    endfunction

    // Element address of entry e of line l for a given stride
    function automatic logic [ADDR_W-1:0] f_addr(input logic [1:0] stride,
                                                 input logic [5:0] l,
                                                 input logic [2:0] e);
        logic [ADDR_W-1:0] a;
        unique case (stride)
            STRIDE_1:  a = {l, e};
            STRIDE_8:  a = {l[5:3], e, l[2:0]};
            default:   a = {e, l};
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dct3_ram.sv */
// ----------------------------------------------------------------------------
// dct3_ram
// 512 x 24 single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dct3_ram
    import dct3_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic signed [MID_W-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output logic signed [MID_W-1:0]       o_rdata
);

    logic signed [MID_W-1:0] r_mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/dct3_mac.sv */
// ----------------------------------------------------------------------------
// dct3_mac
// Eight-lane multiply-accumulate unit with round-half-up and 24-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dct3_mac
    import dct3_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 15,
    parameter int MID_FRAC_BITS  = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [MID_W-1:0]  i_x,
    output logic signed [MID_W-1:0]       o_res
);

    localparam int S1 = COEF_FRAC_BITS - MID_FRAC_BITS;
    localparam int S2 = COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF1 = (S1 == 0) ? '0 : (ACC_W'(1) << (S1 - 1));
    localparam logic signed [ACC_W-1:0] HALF2 = ACC_W'(1) << (S2 - 1);

    logic signed [COEF_W-1:0]       coef [0:7];
    logic signed [COEF_W+MID_W-1:0] r_prod [0:7];
    logic signed [ACC_W-1:0]        r_acc [0:7];
    logic                           r_pv;
    logic                           r_pfirst;

    always_comb begin
        for (int a = 0; a < 8; a++) begin
            coef[a] = i_ctl.inv ? f_basis(i_ctl.b, 3'(a), COEF_FRAC_BITS)
                                : f_basis(3'(a), i_ctl.b, COEF_FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_pfirst <= 1'b0;
        end else begin
            r_pv     <= i_ctl.valid;
            r_pfirst <= (i_ctl.b == 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 8; a++) begin
            if (i_ctl.valid) begin
                r_prod[a] <= coef[a] * i_x;
            end
            if (r_pv) begin
                r_acc[a] <= r_pfirst ? ACC_W'(r_prod[a]) : r_acc[a] + ACC_W'(r_prod[a]);
            end
        end
    end

    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] shv;

    always_comb begin
        sum = r_acc[i_ctl.sel] + (i_ctl.first_pass ? HALF1 : HALF2);
        shv = i_ctl.first_pass ? (sum >>> S1) : (sum >>> S2);
        priority if (shv > ACC_W'(SAT24_MAX)) begin
            o_res = SAT24_MAX;
        end else if (shv < ACC_W'(SAT24_MIN)) begin
            o_res = SAT24_MIN;
        end else begin
            o_res = shv[MID_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dct3d_8x8x8_fwd_inv_core.sv */
// ----------------------------------------------------------------------------
// dct3d_8x8x8_fwd_inv_core
// Orthonormal 8x8x8 DCT-II, forward and inverse, over two element memories.
// ----------------------------------------------------------------------------
// A cube arrives as 64 rows of eight elements, z-major then y; each row is
// accepted, then written to memory element by element. After the 64th row
// the core runs three passes of 64 eight-point transforms, each line using one
// memory read port and one write port (eight reads into eight MAC lanes, pipeline
// drain, eight writes), then sends 64 result rows, each after its eight elements
// are read and rounded. No row is taken while a cube is transformed or sent.
`default_nettype none

`include "dct3d_8x8x8_fwd_inv_core_assert.svh"

module dct3d_8x8x8_fwd_inv_core
    import dct3_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 15,
    parameter int MID_FRAC_BITS  = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // in_0 [15:0], in_1 [31:16], ... in_7 [127:112]
    input  wire logic [127:0]  i_s_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // out_0 [15:0], out_1 [31:16], ... out_7 [127:112]
    output logic [127:0]       o_m_axis_tdata,
    output logic               o_m_axis_tlast,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [7:0]    i_cfg_wdata
);

    localparam int CONV_W = MID_W + 2;
    localparam logic [4:0] RD_LAST  = 5'd7;
    localparam logic [4:0] WR_FIRST = 5'd11;
    localparam logic [4:0] WR_LAST  = 5'd18;
    localparam logic [4:0] OUT_LAST = 5'd8;
    localparam logic signed [CONV_W-1:0] HALF_M = CONV_W'(1) << (MID_FRAC_BITS - 1);
    localparam logic signed [CONV_W-1:0] MASK_M = (CONV_W'(1) << MID_FRAC_BITS) - 1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_LOAD     = 5'b00010,
        ST_PASS     = 5'b00100,
        ST_OUT_RD   = 5'b01000,
        ST_OUT_WAIT = 5'b10000
    } t_state;

    t_state                  r_state;
    logic [5:0]              r_row_cnt;
    logic [ELEM_W-1:0]       r_row [0:7];
    logic [4:0]              r_cnt;
    logic [5:0]              r_line;
    logic [1:0]              r_pass;
    logic                    r_cfg_dir;
    logic [7:0]              r_cfg_dc;
    logic                    r_inv;
    logic [7:0]              r_dc;
    logic                    r_rdv;
    logic [2:0]              r_rdb;
    logic [ELEM_W-1:0]       r_obuf [0:7];

    logic                    in_acc;
    logic [1:0]              stride;
    logic [2:0]              wr_a;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       pass_waddr;
    logic                    wr_phase;
    logic                    cube_we;
    logic                    pass_we;
    logic [ADDR_W-1:0]       cube_waddr;
    logic signed [MID_W-1:0] cube_wdata;
    logic signed [MID_W-1:0] cube_dout;
    logic signed [MID_W-1:0] pass_dout;
    logic signed [MID_W-1:0] mac_x;
    logic signed [MID_W-1:0] mac_res;
    t_mac_ctl                mac_ctl;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT_WAIT);
    assign o_m_axis_tlast  = (r_line == 6'd63);

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            o_m_axis_tdata[j*ELEM_W +: ELEM_W] = r_obuf[j];
        end
    end

    // Forward runs x, y, z; inverse runs z, y, x
    always_comb begin
        unique case (r_pass)
            2'd0:    stride = r_inv ? STRIDE_64 : STRIDE_1;
            2'd1:    stride = STRIDE_8;
            default: stride = r_inv ? STRIDE_1 : STRIDE_64;
        endcase
    end

    assign wr_a       = 3'(r_cnt - WR_FIRST);
    assign wr_phase   = (r_state == ST_PASS) && (r_cnt >= WR_FIRST);
    assign pass_waddr = f_addr(stride, r_line, wr_a);
    assign rd_addr    = (r_state == ST_OUT_RD) ? {r_line, r_cnt[2:0]}
                                               : f_addr(stride, r_line, r_cnt[2:0]);

    assign cube_we    = (r_state == ST_LOAD) || (wr_phase && r_pass == 2'd1);
    assign pass_we    = wr_phase && (r_pass != 2'd1);
    assign cube_waddr = (r_state == ST_LOAD) ? {r_row_cnt, r_cnt[2:0]} : pass_waddr;
    assign cube_wdata = (r_state == ST_LOAD) ? MID_W'($signed(r_row[r_cnt[2:0]])) : mac_res;

    dct3_ram u_cube_ram (
        .i_clk   (i_clk),
        .i_we    (cube_we),
        .i_waddr (cube_waddr),
        .i_wdata (cube_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cube_dout)
    );

    dct3_ram u_pass_ram (
        .i_clk   (i_clk),
        .i_we    (pass_we),
        .i_waddr (pass_waddr),
        .i_wdata (mac_res),
        .i_raddr (rd_addr),
        .o_rdata (pass_dout)
    );

    // Level shift the voxels as the first forward pass reads them
    always_comb begin
        if (r_pass == 2'd1) begin
            mac_x = pass_dout;
        end else if (!r_inv && r_pass == 2'd0) begin
            mac_x = cube_dout - MID_W'(r_dc);
        end else begin
            mac_x = cube_dout;
        end
        mac_ctl.valid      = r_rdv && (r_state == ST_PASS);
        mac_ctl.b          = r_rdb;
        mac_ctl.inv        = r_inv;
        mac_ctl.first_pass = (r_pass == 2'd0);
        mac_ctl.sel        = wr_a;
    end

    dct3_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .MID_FRAC_BITS  (MID_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_x     (mac_x),
        .o_res   (mac_res)
    );

    // Final rounding: ties to even, then saturate or clamp to a voxel
    logic signed [CONV_W-1:0] cv;
    logic signed [CONV_W-1:0] cq;
    logic signed [CONV_W-1:0] crem;
    logic [ELEM_W-1:0]        conv;

    always_comb begin
        cv   = CONV_W'(pass_dout) + (r_inv ? (CONV_W'(r_dc) << MID_FRAC_BITS) : '0);
        cq   = cv >>> MID_FRAC_BITS;
        crem = cv & MASK_M;
        if (crem > HALF_M || (crem == HALF_M && cq[0])) begin
            cq = cq + CONV_W'(1);
        end
        if (r_inv) begin
            priority if (cq < 0) begin
                conv = '0;
            end else if (cq > CONV_W'(255)) begin
                conv = ELEM_W'(255);
            end else begin
                conv = cq[ELEM_W-1:0];
            end
        end else begin
            priority if (cq > CONV_W'(32767)) begin
                conv = 16'h7FFF;
            end else if (cq < -CONV_W'(32768)) begin
                conv = 16'h8000;
            end else begin
                conv = cq[ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dir <= 1'b0;
            r_cfg_dc  <= 8'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIRECTION: r_cfg_dir <= i_cfg_wdata[0];
                REG_DC_OFFSET: r_cfg_dc  <= i_cfg_wdata;
                default:       r_cfg_dir <= r_cfg_dir;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int j = 0; j < 8; j++) begin
                r_row[j] <= i_s_axis_tdata[j*ELEM_W +: ELEM_W];
            end
            if (r_row_cnt == 6'd63) begin
                r_inv <= r_cfg_dir;
                r_dc  <= r_cfg_dc;
            end
        end
        if (r_rdv && r_state == ST_OUT_RD) begin
            r_obuf[r_rdb] <= conv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_cnt <= '0;
            r_cnt     <= '0;
            r_line    <= '0;
            r_pass    <= '0;
            r_rdv     <= 1'b0;
            r_rdb     <= '0;
        end else begin
            r_rdv <= (r_state == ST_PASS || r_state == ST_OUT_RD) && (r_cnt <= RD_LAST);
            r_rdb <= r_cnt[2:0];
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cnt   <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (r_cnt == RD_LAST) begin
                        r_cnt     <= '0;
                        r_row_cnt <= r_row_cnt + 6'd1;
                        r_line    <= '0;
                        r_pass    <= '0;
                        r_state   <= (r_row_cnt == 6'd63) ? ST_PASS : ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_PASS: begin
                    if (r_cnt == WR_LAST) begin
                        r_cnt  <= '0;
                        r_line <= r_line + 6'd1;
                        if (r_line == 6'd63) begin
                            if (r_pass == 2'd2) begin
                                r_state <= ST_OUT_RD;
                            end else begin
                                r_pass <= r_pass + 2'd1;
                            end
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_OUT_RD: begin
                    if (r_cnt == OUT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_OUT_WAIT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_OUT_WAIT: begin
                    if (i_m_axis_tready) begin
                        r_line  <= r_line + 6'd1;
                        r_state <= (r_line == 6'd63) ? ST_IDLE : ST_OUT_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `DCT3_ASSERT_NOW(a_no_write_out, r_state == ST_OUT_RD || r_state == ST_OUT_WAIT, !cube_we && !pass_we, "memory written while sending results")
    `DCT3_ASSERT_NOW(a_ready_excl, o_s_axis_tready, !o_m_axis_tvalid, "request taken while a result is pending")
    `DCT3_ASSERT_NEXT(a_last_row_load, in_acc && r_row_cnt == 6'd63, r_state == ST_LOAD && r_row_cnt == 6'd63, "last row of cube not loaded")
    `DCT3_ASSERT_NOW(a_mac_quiet, wr_phase, !mac_ctl.valid, "accumulation during write-back")

endmodule

`default_nettype wire
